// ===== sv/tls_pkg.sv =====
// tls_pkg: shared types, token kind codes, keyword patterns and character
// classification for the token lexer stream. No dependencies.
`default_nettype none

package tls_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int KEYWORD_CHARS_DEFAULT = 5;
   localparam int QUEUE_DEPTH           = 4;   // power of two

   localparam int KIND_W = 5;
   localparam int POS_W  = 16;
   localparam int CHAR_W = 8;

   typedef logic [KIND_W-1:0] kind_type;

   localparam kind_type KIND_NUMBER = 5'd0;
   localparam kind_type KIND_IDENT  = 5'd1;
   localparam kind_type KIND_VAR    = 5'd2;
   localparam kind_type KIND_PRINT  = 5'd3;
   localparam kind_type KIND_IF     = 5'd4;
   localparam kind_type KIND_ELSE   = 5'd5;
   localparam kind_type KIND_WHILE  = 5'd6;
   localparam kind_type KIND_EQEQ   = 5'd7;
   localparam kind_type KIND_ASSIGN = 5'd8;
   localparam kind_type KIND_NE     = 5'd9;
   localparam kind_type KIND_NOT    = 5'd10;
   localparam kind_type KIND_LE     = 5'd11;
   localparam kind_type KIND_LT     = 5'd12;
   localparam kind_type KIND_GE     = 5'd13;
   localparam kind_type KIND_GT     = 5'd14;
   localparam kind_type KIND_AND    = 5'd15;
   localparam kind_type KIND_OR     = 5'd16;
   localparam kind_type KIND_PLUS   = 5'd17;
   localparam kind_type KIND_MINUS  = 5'd18;
   localparam kind_type KIND_STAR   = 5'd19;
   localparam kind_type KIND_SLASH  = 5'd20;
   localparam kind_type KIND_LPAREN = 5'd21;
   localparam kind_type KIND_RPAREN = 5'd22;
   localparam kind_type KIND_LBRACE = 5'd23;
   localparam kind_type KIND_RBRACE = 5'd24;
   localparam kind_type KIND_SEMI   = 5'd25;
   localparam kind_type KIND_END    = 5'd26;
   localparam kind_type KIND_ERROR  = 5'd27;

   // keyword spellings, first character in the most significant byte
   localparam logic [63:0] KW_VAR   = 64'h0000_0000_0076_6172;
   localparam logic [63:0] KW_PRINT = 64'h0000_0070_7269_6E74;
   localparam logic [63:0] KW_IF    = 64'h0000_0000_0000_6966;
   localparam logic [63:0] KW_ELSE  = 64'h0000_0000_656C_7365;
   localparam logic [63:0] KW_WHILE = 64'h0000_0077_6869_6C65;

   typedef struct packed {
      kind_type          kind;
      logic [POS_W-1:0]  start;
      logic [POS_W-1:0]  length;
      logic [CHAR_W-1:0] bad;
      logic              last;
   } token_type;

   typedef struct packed {
      token_type  first;
      token_type  second;
      logic [1:0] count;
   } step_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == " ") || ((c >= 8'd9) && (c <= 8'd13));
   endfunction

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      case (c)
         "+":     k = KIND_PLUS;
         "-":     k = KIND_MINUS;
         "*":     k = KIND_STAR;
         "/":     k = KIND_SLASH;
         "(":     k = KIND_LPAREN;
         ")":     k = KIND_RPAREN;
         "{":     k = KIND_LBRACE;
         "}":     k = KIND_RBRACE;
         ";":     k = KIND_SEMI;
         default: k = KIND_ERROR;
      endcase
      return k;
   endfunction

endpackage

`default_nettype wire

// ===== sv/tls_scan.sv =====
// tls_scan: scanner state and the per-item decode that yields up to two
// tokens for each accepted item. Depends on tls_pkg.
`default_nettype none

module tls_scan import tls_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEFAULT
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] character,
   input  wire logic       end_of_input,
   output step_type        step
);

   localparam int PREFIX_W = 8 * KEYWORD_CHARS;
   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_NUMBER, MODE_WORD, MODE_EQ, MODE_BANG,
      MODE_LT, MODE_GT, MODE_AMP, MODE_BAR, MODE_DROP
   } mode_type;

   typedef logic [POSITION_BITS-1:0] pos_type;

   mode_type            mode_ff,      mode_in;
   pos_type             position_ff,  position_in;
   pos_type             begin_ff,     begin_in;
   logic [PREFIX_W-1:0] prefix_ff,    prefix_in;
   logic                too_long_ff,  too_long_in;

   token_type flush_tok, start_tok;
   logic      flush_valid, start_valid;
   mode_type  start_mode;
   kind_type  start_single;

   function automatic token_type make_token(input kind_type kind, input pos_type start,
                                            input pos_type len, input logic [7:0] bad);
      token_type                 t;
      logic [POSITION_BITS+15:0] s_ext;
      logic [POSITION_BITS+15:0] l_ext;
      s_ext    = {16'b0, start};
      l_ext    = {16'b0, len};
      t.kind   = kind;
      t.start  = s_ext[15:0];
      t.length = l_ext[15:0];
      t.bad    = bad;
      t.last   = 1'b0;
      return t;
   endfunction

   function automatic kind_type pend_single(input mode_type m);
      kind_type k;
      unique case (m)
         MODE_EQ:   k = KIND_ASSIGN;
         MODE_BANG: k = KIND_NOT;
         MODE_LT:   k = KIND_LT;
         MODE_GT:   k = KIND_GT;
         default:   k = KIND_ERROR;
      endcase
      return k;
   endfunction

   function automatic kind_type pend_double(input mode_type m);
      kind_type k;
      unique case (m)
         MODE_EQ:   k = KIND_EQEQ;
         MODE_BANG: k = KIND_NE;
         MODE_LT:   k = KIND_LE;
         MODE_GT:   k = KIND_GE;
         MODE_AMP:  k = KIND_AND;
         default:   k = KIND_OR;
      endcase
      return k;
   endfunction

   function automatic logic [7:0] pend_char(input mode_type m);
      logic [7:0] c;
      unique case (m)
         MODE_EQ:   c = "=";
         MODE_BANG: c = "!";
         MODE_LT:   c = "<";
         MODE_GT:   c = ">";
         MODE_AMP:  c = "&";
         default:   c = "|";
      endcase
      return c;
   endfunction

   function automatic kind_type word_kind(input logic [PREFIX_W-1:0] prefix,
                                          input logic too_long);
      logic [63:0] p;
      kind_type    k;
      p = 64'(prefix);
      if (too_long)           k = KIND_IDENT;
      else if (p == KW_VAR)   k = KIND_VAR;
      else if (p == KW_PRINT) k = KIND_PRINT;
      else if (p == KW_IF)    k = KIND_IF;
      else if (p == KW_ELSE)  k = KIND_ELSE;
      else if (p == KW_WHILE) k = KIND_WHILE;
      else                    k = KIND_IDENT;
      return k;
   endfunction

   // what the current character does when it opens a new token
   always_comb begin
      start_single = single_kind(character);
      start_valid  = 1'b0;
      start_tok    = make_token(start_single, position_ff, pos_type'(1), 8'd0);
      if (is_space(character)) begin
         start_mode = MODE_IDLE;
      end else if (is_digit(character)) begin
         start_mode = MODE_NUMBER;
      end else if (is_alpha(character) || character == "_") begin
         start_mode = MODE_WORD;
      end else begin
         case (character)
            "=":     start_mode = MODE_EQ;
            "!":     start_mode = MODE_BANG;
            "<":     start_mode = MODE_LT;
            ">":     start_mode = MODE_GT;
            "&":     start_mode = MODE_AMP;
            "|":     start_mode = MODE_BAR;
            default: begin
               start_valid = 1'b1;
               if (start_single == KIND_ERROR) begin
                  start_mode    = MODE_DROP;
                  start_tok.bad = character;
               end else begin
                  start_mode = MODE_IDLE;
               end
            end
         endcase
      end
   end

   always_comb begin
      logic open_token;
      open_token  = 1'b0;
      mode_in     = mode_ff;
      position_in = position_ff;
      begin_in    = begin_ff;
      prefix_in   = prefix_ff;
      too_long_in = too_long_ff;
      flush_valid = 1'b0;
      flush_tok   = make_token(KIND_NUMBER, begin_ff, position_ff - begin_ff, 8'd0);
      step        = '0;

      if (end_of_input) begin
         unique case (mode_ff)
            MODE_NUMBER: flush_valid = 1'b1;
            MODE_WORD: begin
               flush_valid    = 1'b1;
               flush_tok.kind = word_kind(prefix_ff, too_long_ff);
            end
            MODE_EQ, MODE_BANG, MODE_LT, MODE_GT, MODE_AMP, MODE_BAR: begin
               flush_valid = 1'b1;
               flush_tok   = make_token(pend_single(mode_ff), begin_ff, pos_type'(1),
                                        (pend_single(mode_ff) == KIND_ERROR)
                                        ? pend_char(mode_ff) : 8'd0);
            end
            default: flush_valid = 1'b0;
         endcase
         mode_in     = MODE_IDLE;
         position_in = '0;
         begin_in    = '0;
         prefix_in   = '0;
         too_long_in = 1'b0;
      end else begin
         unique case (mode_ff)
            MODE_IDLE: open_token = 1'b1;
            MODE_NUMBER: begin
               if (!is_digit(character)) begin
                  flush_valid = 1'b1;
                  open_token  = 1'b1;
               end
            end
            MODE_WORD: begin
               if (is_alpha(character) || is_digit(character) || character == "_") begin
                  if (prefix_ff[PREFIX_W-1 -: 8] != 8'd0) begin
                     too_long_in = 1'b1;
                  end else begin
                     prefix_in = {prefix_ff[PREFIX_W-9:0], character};
                  end
               end else begin
                  flush_valid    = 1'b1;
                  flush_tok.kind = word_kind(prefix_ff, too_long_ff);
                  open_token     = 1'b1;
               end
            end
            MODE_EQ, MODE_BANG, MODE_LT, MODE_GT: begin
               flush_valid = 1'b1;
               if (character == "=") begin
                  flush_tok = make_token(pend_double(mode_ff), begin_ff, pos_type'(2), 8'd0);
                  mode_in   = MODE_IDLE;
               end else begin
                  flush_tok  = make_token(pend_single(mode_ff), begin_ff, pos_type'(1), 8'd0);
                  open_token = 1'b1;
               end
            end
            MODE_AMP, MODE_BAR: begin
               flush_valid = 1'b1;
               if (character == pend_char(mode_ff)) begin
                  flush_tok = make_token(pend_double(mode_ff), begin_ff, pos_type'(2), 8'd0);
                  mode_in   = MODE_IDLE;
               end else begin
                  // lone & or |: report it and drop the rest of the input
                  flush_tok = make_token(KIND_ERROR, begin_ff, pos_type'(1),
                                         pend_char(mode_ff));
                  mode_in   = MODE_DROP;
               end
            end
            default: mode_in = MODE_DROP;
         endcase

         if (open_token) begin
            mode_in = start_mode;
            if (!is_space(character)) begin
               begin_in = position_ff;
            end
            if (start_mode == MODE_WORD) begin
               prefix_in   = PREFIX_W'(character);
               too_long_in = 1'b0;
            end
         end

         if (position_ff != POS_MAX) begin
            position_in = position_ff + pos_type'(1);
         end
      end

      // order the results: flushed token first, then the new or end token
      if (end_of_input) begin
         step.first  = flush_valid ? flush_tok : make_token(KIND_END, position_ff, '0, 8'd0);
         step.second = make_token(KIND_END, position_ff, '0, 8'd0);
         step.count  = flush_valid ? 2'd2 : 2'd1;
      end else if (flush_valid && open_token && start_valid) begin
         step.first  = flush_tok;
         step.second = start_tok;
         step.count  = 2'd2;
      end else if (flush_valid) begin
         step.first = flush_tok;
         step.count = 2'd1;
      end else if (open_token && start_valid) begin
         step.first = start_tok;
         step.count = 2'd1;
      end
      if (step.count == 2'd2) begin
         step.second.last = 1'b1;
      end else if (step.count == 2'd1) begin
         step.first.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_IDLE;
         position_ff <= '0;
         begin_ff    <= '0;
         prefix_ff   <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         position_ff <= position_in;
         begin_ff    <= begin_in;
         prefix_ff   <= prefix_in;
         too_long_ff <= too_long_in;
      end
   end

`ifndef SYNTH
   a_drop_holds: assert property (@(posedge clock) disable iff (reset)
      (accept && !end_of_input && mode_ff == MODE_DROP) |-> (step.count == 2'd0))
      else $error("tls_scan: result produced while dropping input");
   a_end_resets: assert property (@(posedge clock) disable iff (reset)
      (accept && end_of_input) |=> (mode_ff == MODE_IDLE && position_ff == '0))
      else $error("tls_scan: state not cleared after end item");
   a_position_sat: assert property (@(posedge clock) disable iff (reset)
      (accept && !end_of_input && position_ff == POS_MAX) |=> (position_ff == POS_MAX))
      else $error("tls_scan: position counter wrapped");
`endif

endmodule

`default_nettype wire

// ===== sv/token_lexer_stream.sv =====
// token_lexer_stream: top level, scanner instance and the result token queue.
// Depends on tls_pkg and tls_scan.
`default_nettype none

// One source byte (or an end mark) is taken per cycle and decoded in a single
// pass; its tokens land in a 4-entry queue the cycle after acceptance and leave
// at one token per cycle while rsp_stall is low. An item yields zero, one or
// two tokens, so the input runs at one item per cycle as long as the output
// keeps pace. The input stalls while fewer than two queue entries are free.
// Token text is not carried, only kind, start and length; positions saturate
// at 2^POSITION_BITS - 1.
module token_lexer_stream import tls_pkg::*; #(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT,
   parameter int KEYWORD_CHARS = KEYWORD_CHARS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [7:0]  req_character,
   input  wire logic        req_end_of_input,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [4:0]       rsp_token_kind,
   output logic [15:0]      rsp_token_start,
   output logic [15:0]      rsp_token_length,
   output logic [7:0]       rsp_bad_character,
   output logic             rsp_last_of_run
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   step_type           step;
   logic               accept;
   logic               pop;
   token_type          queue_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   head_ff, head_in;
   logic [PTR_W-1:0]   tail_ff, tail_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   token_type          head_tok;

   assign req_stall = (count_ff > CNT_W'(QUEUE_DEPTH - 2));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && !rsp_stall;

   tls_scan #(
      .POSITION_BITS (POSITION_BITS),
      .KEYWORD_CHARS (KEYWORD_CHARS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .character    (req_character),
      .end_of_input (req_end_of_input),
      .step         (step)
   );

   always_comb begin
      logic [1:0] push_n;
      push_n   = accept ? step.count : 2'd0;
      tail_in  = tail_ff + PTR_W'(push_n);
      head_in  = pop ? head_ff + PTR_W'(1) : head_ff;
      count_in = count_ff + CNT_W'(push_n) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // payload entries need no reset
   always_ff @(posedge clock) begin
      if (accept && step.count != 2'd0) begin
         queue_ff[tail_ff] <= step.first;
      end
      if (accept && step.count == 2'd2) begin
         queue_ff[tail_ff + PTR_W'(1)] <= step.second;
      end
   end

   assign head_tok          = queue_ff[head_ff];
   assign rsp_token_kind    = head_tok.kind;
   assign rsp_token_start   = head_tok.start;
   assign rsp_token_length  = head_tok.length;
   assign rsp_bad_character = head_tok.bad;
   assign rsp_last_of_run   = head_tok.last;

`ifndef SYNTH
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("token_lexer_stream: token queue overflow");
   a_end_gives_token: assert property (@(posedge clock) disable iff (reset)
      (accept && req_end_of_input) |=> rsp_valid)
      else $error("token_lexer_stream: end item produced no token");
   a_last_marks: assert property (@(posedge clock) disable iff (reset)
      (accept && step.count == 2'd2) |-> (step.second.last && !step.first.last))
      else $error("token_lexer_stream: last-of-run flag misplaced");
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (count_ff == '0))
      else $error("token_lexer_stream: queue not empty after reset");
`endif

endmodule

`default_nettype wire
